@@ hdl/nbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_pkg
// Shared types, word indexes and reset values of the north bridge register
// block.
// ----------------------------------------------------------------------------
package nbr_pkg;

    localparam int REG_WORDS_DEF  = 28;
    localparam int WRITABLE_WORDS = 28;
    localparam int BANK_AW        = 5;
    localparam int WORD_W         = 32;

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_XLATE = 2'd2;
    localparam logic [1:0] K_IRQ   = 2'd3;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_PULSE = 2'd1;
    localparam logic [1:0] ACT_RAISE = 2'd2;
    localparam logic [1:0] ACT_LOWER = 2'd3;

    localparam logic [BANK_AW-1:0] W_IDENT0 = 5'd0;
    localparam logic [BANK_AW-1:0] W_GENCFG = 5'd1;
    localparam logic [BANK_AW-1:0] W_IDENT2 = 5'd2;
    localparam logic [BANK_AW-1:0] W_IDENT3 = 5'd3;
    localparam logic [BANK_AW-1:0] W_IDENT4 = 5'd4;
    localparam logic [BANK_AW-1:0] W_MAPCFG = 5'd6;
    localparam logic [BANK_AW-1:0] W_MASK7  = 5'd7;
    localparam logic [BANK_AW-1:0] W_MASK8  = 5'd8;
    localparam logic [BANK_AW-1:0] W_EDGE   = 5'd9;
    localparam logic [BANK_AW-1:0] W_POL    = 5'd11;
    localparam logic [BANK_AW-1:0] W_ENSET  = 5'd12;
    localparam logic [BANK_AW-1:0] W_ENCLR  = 5'd13;
    localparam logic [BANK_AW-1:0] W_EN     = 5'd14;
    localparam logic [BANK_AW-1:0] W_ISR    = 5'd15;
    localparam logic [BANK_AW-1:0] W_MISC26 = 5'd26;
    localparam logic [BANK_AW-1:0] W_MISC27 = 5'd27;

    localparam int GENCFG_RST_BIT = 2;
    localparam int MAP_DIS_BIT    = 16;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } t_bank_wr;

    typedef struct packed {
        logic [1:0]        irq_action;
        logic              config_error;
        logic              config_valid;
        logic [WORD_W-1:0] config_address;
        logic              reset_request;
        logic [WORD_W-1:0] read_data;
    } t_result;

    function automatic logic [WORD_W-1:0] reset_word(input logic [BANK_AW-1:0] idx);
        logic [WORD_W-1:0] v;
        begin
            unique case (idx)
                W_IDENT0: v = 32'h0000_0c40;
                W_GENCFG: v = 32'h0000_1384;
                W_IDENT2: v = 32'h2bff_8010;
                W_IDENT3: v = 32'h255e_0091;
                W_IDENT4: v = 32'h0000_6140;
                W_MASK7:  v = 32'h0000_01ff;
                W_MASK8:  v = 32'h0000_01ff;
                W_MISC26: v = 32'h0000_0008;
                W_MISC27: v = 32'h1000_0000;
                default:  v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/nbr_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_bank
// Register bank memory: one write port, two registered read ports with
// same-edge write bypass, per-word valid bits selecting the reset value.
// ----------------------------------------------------------------------------
module nbr_bank
    import nbr_pkg::*;
#(
    parameter int REG_WORDS = REG_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [BANK_AW-1:0] i_rd_addr_a,
    input  logic [BANK_AW-1:0] i_rd_addr_b,
    input  t_bank_wr           i_wr,
    output logic [WORD_W-1:0]  o_rd_data_a,
    output logic [WORD_W-1:0]  o_rd_data_b
);

    logic [WORD_W-1:0]    r_mem [REG_WORDS];
    logic [REG_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]    r_mem_a, r_mem_b;
    logic [WORD_W-1:0]    r_def_a, r_def_b;
    logic [WORD_W-1:0]    r_byp_data;
    logic                 r_vld_a, r_vld_b;
    logic                 r_byp_a, r_byp_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_mem_a <= r_mem[i_rd_addr_a];
            r_mem_b <= r_mem[i_rd_addr_b];
            r_def_a <= reset_word(i_rd_addr_a);
            r_def_b <= reset_word(i_rd_addr_b);
            r_byp_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_vld[i_rd_addr_a];
                r_vld_b <= r_vld[i_rd_addr_b];
                r_byp_a <= i_wr.en && (i_wr.addr == i_rd_addr_a);
                r_byp_b <= i_wr.en && (i_wr.addr == i_rd_addr_b);
            end
        end
    end

    assign o_rd_data_a = r_byp_a ? r_byp_data : (r_vld_a ? r_mem_a : r_def_a);
    assign o_rd_data_b = r_byp_b ? r_byp_data : (r_vld_b ? r_mem_b : r_def_b);

endmodule

@@ hdl/north_bridge_register_block_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// north_bridge_register_block_core
// Bridge register bank with register read/write, configuration address
// translation and interrupt line decode.
//
// Requests enter on the s_axis channel: s_axis_tuser carries the kind
// (write, read, translate, interrupt), s_axis_tdata the remaining fields.
// Each request gives exactly one result on the m_axis channel, in order.
// The downstream bus number is written through i_cfg_valid / i_cfg_data;
// the user must write it only while no request is in flight (not enforced).
// The bank read and stage one register at the accepting edge; the output
// register loads from stage one whenever it is free and then presents
// the result on m_axis.
// Throughput: one request per cycle while m_axis_tready is high; the bank
// read port and the bypass of the write from the previous request sustain that rate.
// Reset: all words return to their default values at once through per-word
// valid bits; the bus number clears to zero. No clearing pass is needed.
// When m_axis_tready is low the output register holds; one more request
// can sit behind it, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module north_bridge_register_block_core
    import nbr_pkg::*;
#(
    parameter int REG_WORDS = REG_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // offset[18:0], write_data[50:19], access_bytes[53:51], irq_line[58:54]
    input  logic [63:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], reset_request[32], config_address[64:33],
    // config_valid[65], config_error[66], irq_action[68:67]
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int IDX_W = 17;
    localparam int SEL_W = 21;

    function automatic logic [4:0] low_zeros(input logic [SEL_W-1:0] v);
        logic [4:0] n;
        begin
            n = '0;
            for (int i = SEL_W - 1; i >= 0; i--) begin
                if (v[i]) begin
                    n = 5'(i);
                end
            end
            return n;
        end
    endfunction

    logic [18:0]        in_off;
    logic [IDX_W-1:0]   in_idx;
    logic               in_rd_ok, in_wr_ok, accept;
    logic [BANK_AW-1:0] rd_addr_a;

    logic               r_s1_v;
    logic [1:0]         r_s1_kind;
    logic [18:0]        r_s1_off;
    logic [WORD_W-1:0]  r_s1_data;
    logic [2:0]         r_s1_bytes;
    logic [4:0]         r_s1_line;
    logic               r_s1_rd_ok, r_s1_wr_ok;

    logic [WORD_W-1:0]  word_a, word_b;
    logic [WORD_W-1:0]  r_en, n_en;
    logic [7:0]         r_bus;
    logic               r_out_v;
    t_result            r_out, n_out;
    t_bank_wr           bank_wr;
    logic               out_free, s1_go;

    logic [BANK_AW-1:0] s1_idx;
    logic [WORD_W-1:0]  joined;
    logic [SEL_W-1:0]   sel;

    assign in_off   = s_axis_tdata[18:0];
    assign in_idx   = in_off[18:2];
    assign in_rd_ok = in_idx < IDX_W'(REG_WORDS);
    assign in_wr_ok = in_idx < IDX_W'(WRITABLE_WORDS);

    assign out_free      = !r_out_v || m_axis_tready;
    assign s1_go         = r_s1_v && out_free;
    assign s_axis_tready = !r_s1_v || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        unique case (s_axis_tuser)
            K_WRITE, K_READ: rd_addr_a = in_rd_ok ? in_idx[BANK_AW-1:0] : W_IDENT0;
            K_XLATE:         rd_addr_a = W_MAPCFG;
            K_IRQ:           rd_addr_a = W_EDGE;
            default:         rd_addr_a = W_IDENT0;
        endcase
    end

    nbr_bank #(
        .REG_WORDS (REG_WORDS)
    ) u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (W_POL),
        .i_wr        (bank_wr),
        .o_rd_data_a (word_a),
        .o_rd_data_b (word_b)
    );

    assign s1_idx = r_s1_off[BANK_AW+1:2];
    assign joined = {word_a[15:0], r_s1_off[15:0]};
    assign sel    = joined[31:11];

    always_comb begin
        n_out        = '0;
        n_en         = r_en;
        bank_wr.en   = 1'b0;
        bank_wr.addr = s1_idx;
        bank_wr.data = r_s1_data;
        unique case (r_s1_kind)
            K_WRITE: begin
                if (r_s1_wr_ok) begin
                    if (s1_idx == W_GENCFG) begin
                        n_out.reset_request = !word_a[GENCFG_RST_BIT]
                                              && r_s1_data[GENCFG_RST_BIT];
                    end
                    if (s1_idx == W_ENSET) begin
                        n_en = r_en | r_s1_data;
                    end else if (s1_idx == W_ENCLR) begin
                        n_en = r_en & ~r_s1_data;
                    end
                    bank_wr.en = s1_go && (s1_idx != W_EN) && (s1_idx != W_ISR);
                end
            end
            K_READ: begin
                if (r_s1_rd_ok) begin
                    n_out.read_data = (s1_idx == W_EN) ? r_en : word_a;
                end
            end
            K_XLATE: begin
                if (word_a[MAP_DIS_BIT]) begin
                    case (r_s1_bytes)
                        3'd0:    n_out.read_data = 32'h0000_0000;
                        3'd1:    n_out.read_data = 32'h0000_00ff;
                        3'd2:    n_out.read_data = 32'h0000_ffff;
                        3'd3:    n_out.read_data = 32'h00ff_ffff;
                        default: n_out.read_data = 32'hffff_ffff;
                    endcase
                end else if (sel == '0) begin
                    n_out.config_error = 1'b1;
                end else begin
                    n_out.config_address = {1'b1, 7'd0, r_bus, low_zeros(sel),
                                            joined[10:8], joined[7:0]};
                    n_out.config_valid   = 1'b1;
                end
            end
            K_IRQ: begin
                if (word_a[r_s1_line]) begin
                    n_out.irq_action = ACT_PULSE;
                end else if (word_b[r_s1_line]) begin
                    n_out.irq_action = ACT_RAISE;
                end else begin
                    n_out.irq_action = ACT_LOWER;
                end
            end
            default: n_out.irq_action = ACT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= s_axis_tuser;
            r_s1_off   <= in_off;
            r_s1_data  <= s_axis_tdata[50:19];
            r_s1_bytes <= s_axis_tdata[53:51];
            r_s1_line  <= s_axis_tdata[58:54];
            r_s1_rd_ok <= in_rd_ok;
            r_s1_wr_ok <= in_wr_ok;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_en    <= '0;
            r_bus   <= '0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_out_v <= 1'b1;
                r_en    <= n_en;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_bus <= i_cfg_data;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {3'd0, r_out};

`ifndef SYNTHESIS
    a_wr_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bank_wr.en |-> bank_wr.addr != W_EN && bank_wr.addr != W_ISR
                       && bank_wr.addr < BANK_AW'(WRITABLE_WORDS))
        else $error("bank write to a read-only or absent word");

    a_en_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(bank_wr.en && (bank_wr.addr == W_ENSET || bank_wr.addr == W_ENCLR))
        |=> $stable(r_en))
        else $error("enable word changed without a set or clear write");

    a_cfg_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.config_valid && r_out.config_error))
        else $error("translation both valid and in error");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_v)
        else $error("request left stage one without a result");
`endif

endmodule
